[src/lca_pkg.sv]
// ----------------------------------------------------------------------------
// LCA package
// Shared widths and constants of the binary-lifting ancestor block.
// ----------------------------------------------------------------------------
package lca_pkg;
	localparam int NodeW      = 14;
	localparam int MaxNodes   = 16384;
	localparam int LiftLevels = 15;
	localparam int LevelW     = $clog2(LiftLevels);
	localparam int AncDepth   = MaxNodes * LiftLevels;
	localparam int AncAddrW   = $clog2(AncDepth);
	localparam logic [NodeW-1:0] DepthMax = {NodeW{1'b1}};
	localparam logic FuncAdd   = 1'b0;
	localparam logic FuncQuery = 1'b1;

	typedef logic [NodeW-1:0] node_t;

	typedef struct packed {
		logic  func;
		node_t node;
		node_t other;
	} req_t;

	typedef struct packed {
		node_t ancestor;
	} rsp_t;
endpackage

[src/lca_if.sv]
// ----------------------------------------------------------------------------
// LCA stream interface
// Valid/ready channel carrying one request or one result transaction.
// ----------------------------------------------------------------------------
interface lca_req_if;
	logic           valid;
	logic           ready;
	lca_pkg::req_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface lca_rsp_if;
	logic           valid;
	logic           ready;
	lca_pkg::rsp_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[src/lca_tables.sv]
// ----------------------------------------------------------------------------
// LCA tables
// Depth memory and ancestor memory, one port each, registered read data.
// Node 0 reads as zero.
// ----------------------------------------------------------------------------
module lca_tables (
	input  logic                            clk,
	input  logic                            dep_we,
	input  lca_pkg::node_t                  dep_addr,
	input  lca_pkg::node_t                  dep_wdata,
	output lca_pkg::node_t                  dep_rdata,
	input  logic                            anc_we,
	input  lca_pkg::node_t                  anc_node,
	input  logic [lca_pkg::LevelW-1:0]      anc_level,
	input  lca_pkg::node_t                  anc_wdata,
	output lca_pkg::node_t                  anc_rdata
);
	import lca_pkg::*;

	node_t dep_mem [MaxNodes];
	node_t anc_mem [AncDepth];
	node_t dep_q;
	node_t anc_q;
	logic  dep_zero_q;
	logic  anc_zero_q;
	logic [AncAddrW-1:0] anc_addr;

	// flatten node and level into one row index
	assign anc_addr = AncAddrW'(anc_node) * AncAddrW'(LiftLevels) + AncAddrW'(anc_level);

	// depth port
	always_ff @(posedge clk) begin
		if (dep_we)
			dep_mem[dep_addr] <= dep_wdata;
		dep_q      <= dep_mem[dep_addr];
		dep_zero_q <= (dep_addr == '0);
	end

	// ancestor port
	always_ff @(posedge clk) begin
		if (anc_we)
			anc_mem[anc_addr] <= anc_wdata;
		anc_q      <= anc_mem[anc_addr];
		anc_zero_q <= (anc_node == '0);
	end

	assign dep_rdata = dep_zero_q ? '0 : dep_q;
	assign anc_rdata = anc_zero_q ? '0 : anc_q;
endmodule

[src/lowest_common_ancestor_lifting.sv]
// ----------------------------------------------------------------------------
// Lowest common ancestor by binary lifting
// Stores a rooted forest and answers lowest common ancestor queries.
// ----------------------------------------------------------------------------
// An add (func 0) writes the node's depth and its 15 lifting entries: it reads
// the parent depth, writes the depth and level 0, then reads up(n, i-1) and
// up(x, i-1) and writes level i for each further level. A query (func 1) walks
// the levels twice with dependent reads from the one-port ancestor and depth
// memories. It orders the two nodes by depth, lifts the deeper node level by
// level in the first pass, checks the two for equality, lifts both level by
// level in the second pass, and ends with a read of the parent. The result is
// offered when the nodes meet after the first pass, else after that read.
// One transaction is worked at a time. in is not ready until the result
// (queries only) is taken, and it is ready in the cycle after that. Memories
// hold no reset state: only added nodes may be referenced.
module lowest_common_ancestor_lifting (
	input logic        clk,
	input logic        arst_n,
	lca_req_if.sink    in,
	lca_rsp_if.source  out
);
	import lca_pkg::*;

	localparam logic [3:0] StIdle  = 4'd0;
	localparam logic [3:0] StDepA  = 4'd1;  // read depth of a
	localparam logic [3:0] StDepB  = 4'd2;  // read depth of b
	localparam logic [3:0] StDepW  = 4'd3;  // compare, swap
	localparam logic [3:0] StAddP  = 4'd4;  // read parent depth
	localparam logic [3:0] StAddW  = 4'd5;  // write depth and level 0
	localparam logic [3:0] StAddR  = 4'd6;  // read up(n, i-1)
	localparam logic [3:0] StAddR2 = 4'd7;  // read up(x, i-1)
	localparam logic [3:0] StAddWr = 4'd8;  // write level i
	localparam logic [3:0] StL1Rd  = 4'd9;  // read up(a, i)
	localparam logic [3:0] StL1Dp  = 4'd10; // read depth of x
	localparam logic [3:0] StL1Ck  = 4'd11; // decide
	localparam logic [3:0] StL2Ra  = 4'd12; // read up(a, i)
	localparam logic [3:0] StL2Rb  = 4'd13; // read up(b, i)
	localparam logic [3:0] StL2Ck  = 4'd14; // decide
	localparam logic [3:0] StOut   = 4'd15;

	logic [3:0]        state_q;
	logic              wait_q;
	node_t             a_q, b_q, x_q, db_q, res_q;
	logic [LevelW-1:0] lvl_q;
	logic              fin_q;

	logic              dep_we, anc_we;
	node_t             dep_addr, dep_wdata, dep_rdata;
	node_t             anc_node, anc_wdata, anc_rdata;
	logic [LevelW-1:0] anc_level;
	node_t             n_in, o_in;

	// out-of-range fields fold to the sentinel
	assign n_in = (32'(in.data.node)  >= MaxNodes) ? '0 : in.data.node;
	assign o_in = (32'(in.data.other) >= MaxNodes) ? '0 : in.data.other;

	lca_tables u_tables (
		.clk(clk),
		.dep_we(dep_we), .dep_addr(dep_addr), .dep_wdata(dep_wdata), .dep_rdata(dep_rdata),
		.anc_we(anc_we), .anc_node(anc_node), .anc_level(anc_level),
		.anc_wdata(anc_wdata), .anc_rdata(anc_rdata)
	);

	assign in.ready     = (state_q == StIdle);
	assign out.valid    = (state_q == StOut);
	assign out.data.ancestor = res_q;

	// drive memory ports from the sequencer state
	always_comb begin
		dep_we    = 1'b0;
		anc_we    = 1'b0;
		dep_addr  = a_q;
		dep_wdata = '0;
		anc_node  = a_q;
		anc_level = lvl_q;
		anc_wdata = '0;
		unique case (state_q)
			StDepA:  dep_addr = a_q;
			StDepB:  dep_addr = b_q;
			StAddP:  dep_addr = b_q;
			StAddW: begin
				dep_we    = 1'b1;
				dep_addr  = a_q;
				dep_wdata = (b_q == '0) ? '0 :
					((dep_rdata < DepthMax) ? dep_rdata + 1'b1 : dep_rdata);
				anc_we    = 1'b1;
				anc_level = '0;
				anc_wdata = b_q;
			end
			StAddR: begin
				anc_node  = a_q;
				anc_level = lvl_q - 1'b1;
			end
			StAddR2: begin
				anc_node  = anc_rdata;
				anc_level = lvl_q - 1'b1;
			end
			StAddWr: begin
				anc_we    = 1'b1;
				anc_node  = a_q;
				anc_wdata = anc_rdata;
			end
			StL1Rd:  anc_node = a_q;
			StL1Dp:  dep_addr = anc_rdata;
			StL2Ra:  anc_node = a_q;
			StL2Rb:  anc_node = b_q;
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			wait_q  <= 1'b0;
			fin_q   <= 1'b0;
		end else begin
			unique case (state_q)
				StIdle: if (in.valid) begin
					a_q <= n_in;
					b_q <= o_in;
					if (in.data.func == FuncAdd) begin
						state_q <= (n_in == '0) ? StIdle : StAddP;
					end else if (n_in == '0 || o_in == '0) begin
						res_q   <= '0;
						state_q <= StOut;
					end else begin
						state_q <= StDepA;
					end
				end
				StAddP: state_q <= StAddW;
				StAddW: begin
					lvl_q   <= LevelW'(1);
					state_q <= (LiftLevels > 1) ? StAddR : StIdle;
				end
				StAddR:  state_q <= StAddR2;
				StAddR2: state_q <= StAddWr;
				StAddWr: begin
					if (32'(lvl_q) == LiftLevels - 1) begin
						state_q <= StIdle;
					end else begin
						lvl_q   <= lvl_q + 1'b1;
						state_q <= StAddR;
					end
				end
				StDepA: state_q <= StDepB;
				StDepB: begin
					x_q     <= dep_rdata;
					state_q <= StDepW;
				end
				StDepW: begin
					// keep the deeper node in a
					if (x_q < dep_rdata) begin
						a_q  <= b_q;
						b_q  <= a_q;
						db_q <= x_q;
					end else begin
						db_q <= dep_rdata;
					end
					lvl_q   <= LevelW'(LiftLevels - 1);
					state_q <= StL1Rd;
				end
				StL1Rd: state_q <= StL1Dp;
				StL1Dp: begin
					x_q     <= anc_rdata;
					state_q <= StL1Ck;
				end
				StL1Ck: begin
					if (x_q != '0 && dep_rdata >= db_q)
						a_q <= x_q;
					if (lvl_q == '0) begin
						state_q <= StL2Ra;
						lvl_q   <= LevelW'(LiftLevels - 1);
						fin_q   <= 1'b0;
						wait_q  <= 1'b1;
					end else begin
						lvl_q   <= lvl_q - 1'b1;
						state_q <= StL1Rd;
					end
				end
				StL2Ra: begin
					if (wait_q) begin
						// equal after the first pass: a is the answer
						wait_q <= 1'b0;
						if (a_q == b_q) begin
							res_q   <= a_q;
							state_q <= StOut;
						end
					end else begin
						state_q <= StL2Rb;
					end
				end
				StL2Rb: begin
					x_q     <= anc_rdata;
					state_q <= StL2Ck;
				end
				StL2Ck: begin
					if (fin_q) begin
						res_q   <= x_q;
						state_q <= StOut;
					end else begin
						if (x_q != anc_rdata) begin
							a_q <= x_q;
							b_q <= anc_rdata;
						end
						if (lvl_q == '0) begin
							fin_q <= 1'b1;
						end else begin
							lvl_q <= lvl_q - 1'b1;
						end
						state_q <= StL2Ra;
					end
				end
				StOut: if (out.ready) state_q <= StIdle;
				default: state_q <= StIdle;
			endcase
		end
	end
endmodule
